>>> rtl/fsr_pkg.sv
// shared action codes, result kinds and scan metadata type for the frame store
package fsr_pkg;

  localparam logic [1:0] ACT_AREA  = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_SCAN  = 2'd2;

  localparam logic KIND_FLUSH = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [5:0] col;
    logic [5:0] row;
    logic       last;
  } scan_meta_t;

endpackage

>>> rtl/frame_store_rect_write_rgb565_scanout_top.sv
// top level of the rgb565 frame store with rectangle writes and rgb888 scanout
//
//  channel   direction  handshake                      payload
//  input     in         start && !busy                 in_action, in_x_start .. in_pixel_value
//  result    out        out_strobe, one cycle, no stall out_result_kind .. out_frame_last
//
//  one beat is accepted per cycle whenever busy is low
//  a result's strobe passes through the s1 register and then the result register after its beat is accepted
//  frame memory has one write port and one registered read port; a beat uses at most one of them
//  after reset busy stays high while the clearing pass writes zero to every frame memory word
//  the receiver cannot stall; results are never held
module frame_store_rect_write_rgb565_scanout_top
  import fsr_pkg::*;
#(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_x_start,
  input  logic [5:0]  in_y_start,
  input  logic [5:0]  in_x_end,
  input  logic [5:0]  in_y_end,
  input  logic [15:0] in_pixel_value,
  output logic        out_strobe,
  output logic        out_result_kind,
  output logic [5:0]  out_pixel_column,
  output logic [5:0]  out_pixel_row,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_last
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          accept;
  logic          clearing;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          flush;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  scan_meta_t    scan;

  assign busy   = clearing;
  assign accept = start && !clearing;

  fsr_write_ctl #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .AW           (AW)
  ) u_write (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .action  (in_action),
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (in_x_end),
    .y_end   (in_y_end),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .flush   (flush)
  );

  fsr_scan_ctl #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .AW           (AW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .action  (in_action),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .scan    (scan)
  );

  fsr_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (in_pixel_value),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  fsr_pixel_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .flush            (flush),
    .scan             (scan),
    .rd_data          (rd_data),
    .out_strobe       (out_strobe),
    .out_result_kind  (out_result_kind),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_frame_last   (out_frame_last)
  );

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe during clearing pass");

  a_ignored_beat_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action != ACT_PIXEL && in_action != ACT_SCAN) |-> ##2 !out_strobe)
    else $error("area or unused beat produced a result");

  a_no_beat_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##2 !out_strobe)
    else $error("result without accepted beat");

endmodule

>>> rtl/fsr_frame_ram.sv
// frame memory with one write port, one registered read port and a clearing pass after reset
module fsr_frame_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  output logic          clearing
);

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_data_r;
  logic          clr_active_r;
  logic          clr_active_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] clr_addr_nxt;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= 16'd0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_active_r;

  // no beat may touch the memory while it is being cleared
  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!wr_en && !rd_en))
    else $error("frame memory accessed during clearing pass");

  a_clear_ends_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_active_r && !clr_active_nxt) |-> (clr_addr_r == AW'(DEPTH - 1)))
    else $error("clearing pass ended early");

  a_clear_never_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_active_r |=> !clr_active_r)
    else $error("clearing pass restarted without reset");

endmodule

>>> rtl/fsr_write_ctl.sv
// dirty rectangle register set and raster write cursor
module fsr_write_ctl
  import fsr_pkg::*;
#(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64,
  parameter int AW = (FRAME_WIDTH * FRAME_HEIGHT > 1) ?
                     $clog2(FRAME_WIDTH * FRAME_HEIGHT) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [1:0]    action,
  input  logic [5:0]    x_start,
  input  logic [5:0]    y_start,
  input  logic [5:0]    x_end,
  input  logic [5:0]    y_end,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic          flush
);

  logic [5:0]  area_left_r,   area_left_nxt;
  logic [5:0]  area_right_r,  area_right_nxt;
  logic [5:0]  area_bottom_r, area_bottom_nxt;
  logic [5:0]  write_col_r,   write_col_nxt;
  logic [5:0]  write_row_r,   write_row_nxt;
  logic        area_open_r,   area_open_nxt;
  logic        area_ok;
  logic        pix_ok;
  logic        at_end_col;
  logic        at_end;
  logic        in_frame;
  logic [31:0] lin;

  assign area_ok    = accept && (action == ACT_AREA) && !(x_end < x_start || y_end < y_start);
  assign pix_ok     = accept && (action == ACT_PIXEL) && area_open_r;
  assign at_end_col = (write_col_r == area_right_r);
  assign at_end     = at_end_col && (write_row_r == area_bottom_r);
  assign in_frame   = (int'(write_col_r) < FRAME_WIDTH) && (int'(write_row_r) < FRAME_HEIGHT);
  assign lin        = 32'(write_row_r) * 32'(FRAME_WIDTH) + 32'(write_col_r);

  assign wr_en   = pix_ok && in_frame;
  assign wr_addr = AW'(lin);
  assign flush   = pix_ok && at_end;

  always_comb begin
    area_left_nxt   = area_left_r;
    area_right_nxt  = area_right_r;
    area_bottom_nxt = area_bottom_r;
    write_col_nxt   = write_col_r;
    write_row_nxt   = write_row_r;
    area_open_nxt   = area_open_r;
    if (area_ok) begin
      area_left_nxt   = x_start;
      area_right_nxt  = x_end;
      area_bottom_nxt = y_end;
      write_col_nxt   = x_start;
      write_row_nxt   = y_start;
      area_open_nxt   = 1'b1;
    end else if (pix_ok) begin
      if (at_end) begin
        area_open_nxt = 1'b0;
      end else if (at_end_col) begin
        write_col_nxt = area_left_r;
        write_row_nxt = write_row_r + 1'b1;
      end else begin
        write_col_nxt = write_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_left_r   <= '0;
      area_right_r  <= '0;
      area_bottom_r <= '0;
      write_col_r   <= '0;
      write_row_r   <= '0;
      area_open_r   <= 1'b0;
    end else begin
      area_left_r   <= area_left_nxt;
      area_right_r  <= area_right_nxt;
      area_bottom_r <= area_bottom_nxt;
      write_col_r   <= write_col_nxt;
      write_row_r   <= write_row_nxt;
      area_open_r   <= area_open_nxt;
    end
  end

  a_flush_closes_area: assert property (@(posedge clk) disable iff (!rst_n)
    flush |=> !area_open_r)
    else $error("area still open after flush");

  a_cursor_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    area_ok |=> (area_open_r && write_col_r <= area_right_r && write_row_r <= area_bottom_r))
    else $error("write cursor outside new area");

  a_write_needs_area: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> area_open_r)
    else $error("pixel stored with no open area");

endmodule

>>> rtl/fsr_scan_ctl.sv
// raster scan cursor with linear read address
module fsr_scan_ctl
  import fsr_pkg::*;
#(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64,
  parameter int AW = (FRAME_WIDTH * FRAME_HEIGHT > 1) ?
                     $clog2(FRAME_WIDTH * FRAME_HEIGHT) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [1:0]    action,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output scan_meta_t    scan
);

  localparam int SCW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int SRW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  logic [SCW-1:0] scan_col_r,  scan_col_nxt;
  logic [SRW-1:0] scan_row_r,  scan_row_nxt;
  logic [AW-1:0]  scan_addr_r, scan_addr_nxt;
  logic           col_last;
  logic           row_last;

  assign col_last = (scan_col_r == SCW'(FRAME_WIDTH - 1));
  assign row_last = (scan_row_r == SRW'(FRAME_HEIGHT - 1));

  assign rd_en      = accept && (action == ACT_SCAN);
  assign rd_addr    = scan_addr_r;
  assign scan.valid = rd_en;
  assign scan.col   = 6'(scan_col_r);
  assign scan.row   = 6'(scan_row_r);
  assign scan.last  = col_last && row_last;

  always_comb begin
    scan_col_nxt  = scan_col_r;
    scan_row_nxt  = scan_row_r;
    scan_addr_nxt = scan_addr_r;
    if (rd_en) begin
      if (col_last) begin
        scan_col_nxt = '0;
        if (row_last) begin
          scan_row_nxt  = '0;
          scan_addr_nxt = '0;
        end else begin
          scan_row_nxt  = scan_row_r + 1'b1;
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end else begin
        scan_col_nxt  = scan_col_r + 1'b1;
        scan_addr_nxt = scan_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r  <= '0;
      scan_row_r  <= '0;
      scan_addr_r <= '0;
    end else begin
      scan_col_r  <= scan_col_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_addr_r <= scan_addr_nxt;
    end
  end

  a_wrap_to_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && scan.last) |=> (scan_col_r == '0 && scan_row_r == '0 && scan_addr_r == '0))
    else $error("scan cursor did not wrap to origin");

  a_origin_means_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_col_r == '0 && scan_row_r == '0) |-> (scan_addr_r == '0))
    else $error("scan address out of step with cursor");

  a_cursor_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !rd_en |=> $stable(scan_addr_r))
    else $error("scan cursor moved without scan beat");

endmodule

>>> rtl/fsr_pixel_out.sv
// result stage: rgb565 to rgb888 expansion and result register
module fsr_pixel_out
  import fsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        flush,
  input  scan_meta_t  scan,
  input  logic [15:0] rd_data,
  output logic        out_strobe,
  output logic        out_result_kind,
  output logic [5:0]  out_pixel_column,
  output logic [5:0]  out_pixel_row,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_last
);

  localparam int RED_LSB   = 11;
  localparam int GREEN_LSB = 5;

  logic       s1_flush_r;
  scan_meta_t s1_scan_r;
  logic [4:0] r5;
  logic [5:0] g6;
  logic [4:0] b5;

  logic       strobe_r;
  logic       kind_r;
  logic [5:0] col_r;
  logic [5:0] row_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic       last_r;

  assign r5 = rd_data[RED_LSB +: 5];
  assign g6 = rd_data[GREEN_LSB +: 6];
  assign b5 = rd_data[0 +: 5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_flush_r <= 1'b0;
      s1_scan_r  <= '0;
    end else begin
      s1_flush_r <= flush;
      s1_scan_r  <= scan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s1_flush_r || s1_scan_r.valid;
    end
  end

  // flush results carry all-zero fields
  always_ff @(posedge clk) begin
    if (s1_scan_r.valid) begin
      kind_r  <= KIND_SCAN;
      col_r   <= s1_scan_r.col;
      row_r   <= s1_scan_r.row;
      red_r   <= {r5, r5[4:2]};
      green_r <= {g6, g6[5:4]};
      blue_r  <= {b5, b5[4:2]};
      last_r  <= s1_scan_r.last;
    end else begin
      kind_r  <= KIND_FLUSH;
      col_r   <= '0;
      row_r   <= '0;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      last_r  <= 1'b0;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_result_kind  = kind_r;
  assign out_pixel_column = col_r;
  assign out_pixel_row    = row_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_frame_last   = last_r;

  a_scan_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    scan.valid |-> ##2 (strobe_r && kind_r == KIND_SCAN))
    else $error("scan beat did not produce scan result");

  a_flush_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    flush |-> ##2 (strobe_r && kind_r == KIND_FLUSH))
    else $error("flush beat did not produce flush result");

  a_no_dual_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(flush && scan.valid))
    else $error("flush and scan in the same beat");

endmodule
